### rtl/bsp_pkg.sv
// Shared types and constants for the byte stack push/pop block.
// No dependencies; imported by every module of the block.
package bsp_pkg;

  localparam int PTR_W  = 13;
  localparam int VAL_W  = 64;
  localparam int MODE_W = 3;
  localparam int STAT_W = 2;
  localparam int BYTE_W = 8;
  localparam int LANES  = 8;
  localparam int LANE_W = 3;

  localparam logic [PTR_W-1:0] LIMIT_RESET = 13'd4096;

  localparam logic [MODE_W-1:0] MODE_PUSH_BYTE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POP_BYTE  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PUSH_WORD = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_WORD  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SET_PTR   = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVER  = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDER = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [VAL_W-1:0]  push_value;
    logic [PTR_W-1:0]  new_pointer;
  } in_word_t;

  typedef struct packed {
    logic [VAL_W-1:0]  pop_value;
    logic [PTR_W-1:0]  pointer;
    logic [STAT_W-1:0] status;
  } out_word_t;

  // How to gather a popped value from the lane read ports.
  typedef struct packed {
    logic [LANE_W-1:0] lane0;
    logic [LANE_W:0]   nbytes;
  } pop_info_t;

endpackage

### rtl/bsp_lane_ram.sv
// One byte lane of the stack memory: single write port, registered read.
// Depends on bsp_pkg for the byte width.
module bsp_lane_ram #(
  parameter int ROWS  = 512,
  parameter int ROW_W = 9
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ROW_W-1:0]           addr,
  input  logic [bsp_pkg::BYTE_W-1:0] wdata,
  output logic [bsp_pkg::BYTE_W-1:0] rdata
);
  import bsp_pkg::*;

  logic [BYTE_W-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[addr];
  end

endmodule

### rtl/bsp_ctrl.sv
// Pointer, limit and status logic; maps each word onto the byte lanes.
// Depends on bsp_pkg for types, mode and status codes.
module bsp_ctrl #(
  parameter int STACK_BYTES = 4096,
  parameter int WORD_BYTES  = 8,
  parameter int ROW_W       = 9
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  bsp_pkg::in_word_t             cmd,
  input  logic                          cfg_we,
  input  logic [bsp_pkg::PTR_W-1:0]     cfg_data,
  output logic [bsp_pkg::LANES-1:0]     lane_we,
  output logic [ROW_W-1:0]              lane_row   [bsp_pkg::LANES],
  output logic [bsp_pkg::BYTE_W-1:0]    lane_wdata [bsp_pkg::LANES],
  output bsp_pkg::pop_info_t            info,
  output logic                          done,
  output logic [bsp_pkg::PTR_W-1:0]     sp,
  output logic [bsp_pkg::STAT_W-1:0]    status
);
  import bsp_pkg::*;

  localparam logic [PTR_W:0] SB = (PTR_W+1)'(STACK_BYTES);
  localparam logic [PTR_W:0] WB = (PTR_W+1)'(WORD_BYTES);

  logic [PTR_W-1:0]  limit;
  logic [PTR_W-1:0]  sp_next;
  logic [STAT_W-1:0] status_next;
  pop_info_t         info_next;
  logic [PTR_W:0]    lim, ptr_ext, n, base;
  logic              is_push, is_pop, push_ok, pop_ok;

  always_comb begin
    ptr_ext = {1'b0, sp};
    lim     = ({1'b0, limit} < SB) ? {1'b0, limit} : SB;
    is_push = (cmd.mode == MODE_PUSH_BYTE) || (cmd.mode == MODE_PUSH_WORD);
    is_pop  = (cmd.mode == MODE_POP_BYTE) || (cmd.mode == MODE_POP_WORD);
    n       = ((cmd.mode == MODE_PUSH_WORD) || (cmd.mode == MODE_POP_WORD)) ?
              WB : (PTR_W+1)'(1);
    push_ok = (ptr_ext + n) <= lim;
    pop_ok  = ptr_ext >= n;
    base    = is_pop ? ptr_ext - n : ptr_ext;

    sp_next     = sp;
    status_next = ST_OK;
    unique case (cmd.mode)
      MODE_PUSH_BYTE, MODE_PUSH_WORD: begin
        if (push_ok) sp_next = PTR_W'(ptr_ext + n);
        else         status_next = ST_OVER;
      end
      MODE_POP_BYTE, MODE_POP_WORD: begin
        if (pop_ok) sp_next = PTR_W'(base);
        else        status_next = ST_UNDER;
      end
      MODE_SET_PTR: begin
        sp_next = ({1'b0, cmd.new_pointer} < SB) ? cmd.new_pointer : PTR_W'(SB);
      end
      default: ;
    endcase

    info_next.lane0  = base[LANE_W-1:0];
    info_next.nbytes = (is_pop && pop_ok) ? n[LANE_W:0] : '0;
  end

  // Byte k of the word lands in lane (base + k) mod LANES; lanes below the
  // starting lane wrap into the next row.
  always_comb begin
    logic [LANE_W-1:0] off;
    logic [PTR_W:0]    row0;
    row0 = base >> LANE_W;
    for (int l = 0; l < LANES; l++) begin
      off           = LANE_W'(l) - base[LANE_W-1:0];
      lane_we[l]    = accept && is_push && push_ok && ((PTR_W+1)'(off) < n);
      lane_wdata[l] = cmd.push_value[off*BYTE_W +: BYTE_W];
      lane_row[l]   = (LANE_W'(l) >= base[LANE_W-1:0]) ? ROW_W'(row0) :
                      ROW_W'(row0 + (PTR_W+1)'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp   <= '0;
      done <= 1'b0;
    end else begin
      done <= accept;
      if (accept) sp <= sp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
      info   <= info_next;
    end
  end

endmodule

### rtl/byte_stack_push_pop.sv
// Byte-addressed LIFO stack over eight byte-lane memories.
// The result is registered and appears in the cycle after start is taken, for one cycle.
// Throughput: one word per cycle; each word addresses every lane at once.
// busy is high only during reset. Reset clears the pointer to zero and the
// limit to 4096; memory contents are not cleared. The receiver cannot stall.
module byte_stack_push_pop #(
  parameter int STACK_BYTES = 4096,
  parameter int WORD_BYTES  = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  bsp_pkg::in_word_t         cmd,
  output logic                      done,
  output bsp_pkg::out_word_t        result,
  input  logic                      cfg_we,
  input  logic [bsp_pkg::PTR_W-1:0] cfg_data
);
  import bsp_pkg::*;

  localparam int ROWS  = (STACK_BYTES + LANES - 1) / LANES;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic              accept;
  logic [LANES-1:0]  lane_we;
  logic [ROW_W-1:0]  lane_row   [LANES];
  logic [BYTE_W-1:0] lane_wdata [LANES];
  logic [BYTE_W-1:0] lane_rdata [LANES];
  pop_info_t         info;
  logic [PTR_W-1:0]  sp;
  logic [STAT_W-1:0] status;
  logic [VAL_W-1:0]  pop_value;

  assign busy   = rst;
  assign accept = start && !busy;

  bsp_ctrl #(
    .STACK_BYTES(STACK_BYTES),
    .WORD_BYTES (WORD_BYTES),
    .ROW_W      (ROW_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .lane_we   (lane_we),
    .lane_row  (lane_row),
    .lane_wdata(lane_wdata),
    .info      (info),
    .done      (done),
    .sp        (sp),
    .status    (status)
  );

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    bsp_lane_ram #(
      .ROWS (ROWS),
      .ROW_W(ROW_W)
    ) u_ram (
      .clk  (clk),
      .we   (lane_we[l]),
      .addr (lane_row[l]),
      .wdata(lane_wdata[l]),
      .rdata(lane_rdata[l])
    );
  end

  // Rotate lane read data back into byte order; zero the bytes not popped.
  always_comb begin
    logic [LANE_W-1:0] lane;
    for (int k = 0; k < LANES; k++) begin
      lane = info.lane0 + LANE_W'(k);
      pop_value[k*BYTE_W +: BYTE_W] = ((LANE_W+1)'(k) < info.nbytes) ?
                                      lane_rdata[lane] : '0;
    end
  end

  always_comb begin
    result.pop_value = pop_value;
    result.pointer   = sp;
    result.status    = status;
  end

endmodule

### rtl/bsp_checker.sv
// Port-level checks for byte_stack_push_pop, bound to the top level.
// Depends on bsp_pkg for types and status codes.
module bsp_checker #(
  parameter int STACK_BYTES = 4096,
  parameter int WORD_BYTES  = 8
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input bsp_pkg::in_word_t         cmd,
  input logic                      done,
  input bsp_pkg::out_word_t        result
);
  import bsp_pkg::*;

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("accepted word produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done)
    else $error("result without an accepted word");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ({1'b0, result.pointer} <= (PTR_W+1)'(STACK_BYTES)))
    else $error("pointer beyond stack memory");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status != ST_OK)) |-> (result.pop_value == '0))
    else $error("error result carries data");

  a_under_ptr: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == ST_UNDER)) |->
      ({1'b0, result.pointer} < (PTR_W+1)'(WORD_BYTES)))
    else $error("underflow with enough bytes on the stack");

endmodule

bind byte_stack_push_pop bsp_checker #(
  .STACK_BYTES(STACK_BYTES),
  .WORD_BYTES (WORD_BYTES)
) u_bsp_checker (.*);

### bench/byte_stack_checker.sv
// Checker for the byte stack: watches the command and result channels and
// the limit register port, predicts each result and compares field by field.
// Depends on bsp_pkg for the word types, modes and status codes.
module byte_stack_checker #(
  parameter int STACK_BYTES = 4096,
  parameter int WORD_BYTES  = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  bsp_pkg::in_word_t         cmd,
  input  logic                      done,
  input  bsp_pkg::out_word_t        result,
  input  logic                      cfg_we,
  input  logic [bsp_pkg::PTR_W-1:0] cfg_data,
  output int                        outstanding,
  output int                        fail_count
);
  import bsp_pkg::*;

  logic [BYTE_W-1:0] stack_mem [STACK_BYTES];
  int unsigned       stack_ptr;
  int unsigned       stack_lim;
  out_word_t         expected_results [$];
  int                errors = 0;

  task automatic report(input string field, input logic [VAL_W-1:0] want,
                        input logic [VAL_W-1:0] got);
    errors++;
    $display("%0t mismatch on %s: expected %h actual %h", $time, field, want, got);
  endtask

  // Apply one stack operation to the shadow state and form its result word.
  task automatic apply_stack_op(input in_word_t c, output out_word_t r);
    int unsigned      eff_lim;
    int unsigned      n;
    int unsigned      k;
    logic [VAL_W-1:0] popped;
    eff_lim = (stack_lim < STACK_BYTES) ? stack_lim : STACK_BYTES;
    n = (c.mode == MODE_PUSH_BYTE || c.mode == MODE_POP_BYTE) ? 1 : WORD_BYTES;
    popped = '0;
    r.status = ST_OK;
    unique case (c.mode)
      MODE_PUSH_BYTE, MODE_PUSH_WORD: begin
        if (stack_ptr + n > eff_lim) begin
          r.status = ST_OVER;
        end else begin
          for (k = 0; k < n; k++) stack_mem[stack_ptr + k] = c.push_value[BYTE_W*k +: BYTE_W];
          stack_ptr += n;
        end
      end
      MODE_POP_BYTE, MODE_POP_WORD: begin
        if (stack_ptr < n || stack_ptr > STACK_BYTES) begin
          r.status = ST_UNDER;
        end else begin
          for (k = 0; k < n; k++) popped[BYTE_W*k +: BYTE_W] = stack_mem[stack_ptr - n + k];
          stack_ptr -= n;
        end
      end
      MODE_SET_PTR: begin
        stack_ptr = (c.new_pointer < STACK_BYTES) ? c.new_pointer : STACK_BYTES;
      end
      default: begin
      end
    endcase
    r.pop_value = popped;
    r.pointer   = stack_ptr[PTR_W-1:0];
  endtask

  always @(posedge clk) begin : watch
    out_word_t want;
    out_word_t pred;
    if (rst) begin
      stack_ptr = 0;
      stack_lim = LIMIT_RESET;
      expected_results.delete();
    end else begin
      if (cfg_we) stack_lim = cfg_data;
      // Compare before queuing: a result always belongs to an earlier word.
      if (done) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t unexpected result: expected none actual %h", $time, result);
        end else begin
          want = expected_results.pop_front();
          if (result.pop_value !== want.pop_value)
            report("pop_value", want.pop_value, result.pop_value);
          if (result.pointer !== want.pointer)
            report("pointer", VAL_W'(want.pointer), VAL_W'(result.pointer));
          if (result.status !== want.status)
            report("status", VAL_W'(want.status), VAL_W'(result.status));
        end
      end
      if (start && !busy) begin
        apply_stack_op(cmd, pred);
        expected_results.push_back(pred);
      end
    end
    outstanding <= expected_results.size();
    fail_count  <= errors;
  end

endmodule

### bench/testbench.sv
// Top of the byte stack bench: clock, reset, limit writes and command stimulus.
// Instantiates byte_stack_push_pop and byte_stack_checker; depends on bsp_pkg.
module testbench;
  import bsp_pkg::*;

  localparam int STACK_BYTES = 4096;
  localparam int WORD_BYTES  = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 250;

  localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = MODE_SET_PTR + 3'd1;
  localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = '1;
  localparam logic [PTR_W-1:0]  PTR_TOP          = '1;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  in_word_t         cmd = '0;
  logic             done;
  out_word_t        result;
  logic             cfg_we = 1'b0;
  logic [PTR_W-1:0] cfg_data = '0;
  int               outstanding;
  int               fail_count;

  int               cycle_count = 0;
  int               idle_pct = 35;

  // Stimulus-side view of the stack, used to keep pops on written bytes and to aim pointer loads.
  int unsigned      trk_ptr = 0;
  int unsigned      trk_limit = LIMIT_RESET;
  bit               trk_written [STACK_BYTES];

  byte_stack_push_pop #(
    .STACK_BYTES (STACK_BYTES),
    .WORD_BYTES  (WORD_BYTES)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .cmd      (cmd),
    .done     (done),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  byte_stack_checker #(
    .STACK_BYTES (STACK_BYTES),
    .WORD_BYTES  (WORD_BYTES)
  ) i_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .done        (done),
    .result      (result),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic in_word_t mk(input logic [MODE_W-1:0] m, input logic [VAL_W-1:0] v,
                                  input logic [PTR_W-1:0] p);
    in_word_t w;
    w.mode        = m;
    w.push_value  = v;
    w.new_pointer = p;
    return w;
  endfunction

  // A pop is safe when it underflows or every byte it reads was written.
  function automatic bit pop_safe(input int unsigned n);
    int unsigned k;
    if (trk_ptr < n) return 1'b1;
    for (k = trk_ptr - n; k < trk_ptr; k++) if (!trk_written[k]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic track(input in_word_t w);
    int unsigned eff_lim;
    int unsigned n;
    int unsigned k;
    eff_lim = (trk_limit < STACK_BYTES) ? trk_limit : STACK_BYTES;
    n = (w.mode == MODE_PUSH_BYTE || w.mode == MODE_POP_BYTE) ? 1 : WORD_BYTES;
    unique case (w.mode)
      MODE_PUSH_BYTE, MODE_PUSH_WORD: begin
        if (trk_ptr + n <= eff_lim) begin
          for (k = 0; k < n; k++) trk_written[trk_ptr + k] = 1'b1;
          trk_ptr += n;
        end
      end
      MODE_POP_BYTE, MODE_POP_WORD: begin
        if (trk_ptr >= n) trk_ptr -= n;
      end
      MODE_SET_PTR: begin
        trk_ptr = (w.new_pointer < STACK_BYTES) ? w.new_pointer : STACK_BYTES;
      end
      default: begin
      end
    endcase
  endtask

  // Present a word, hold it until taken, then idle at random.
  task automatic send(input in_word_t w);
    track(w);
    cmd   <= w;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_limit(input logic [PTR_W-1:0] v);
    drain();
    cfg_data <= v;
    cfg_we   <= 1'b1;
    @(posedge clk);
    cfg_we   <= 1'b0;
    trk_limit = v;
  endtask

  task automatic random_item(output in_word_t w);
    int unsigned r;
    w.push_value  = {$urandom, $urandom};
    w.new_pointer = PTR_W'($urandom_range(PTR_TOP, 0));
    r = $urandom_range(99);
    if (r < 24) begin
      w.mode = MODE_PUSH_BYTE;
    end else if (r < 48) begin
      w.mode = MODE_POP_BYTE;
    end else if (r < 68) begin
      w.mode = MODE_PUSH_WORD;
    end else if (r < 88) begin
      w.mode = MODE_POP_WORD;
    end else if (r < 95) begin
      w.mode = MODE_SET_PTR;
      // Mostly move down into the written region; now and then jump anywhere.
      if ($urandom_range(3) != 0) w.new_pointer = PTR_W'($urandom_range(trk_ptr, 0));
    end else begin
      w.mode = MODE_W'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST));
    end
    if (w.mode == MODE_POP_BYTE && !pop_safe(1)) w.mode = MODE_PUSH_BYTE;
    if (w.mode == MODE_POP_WORD && !pop_safe(WORD_BYTES)) w.mode = MODE_PUSH_WORD;
  endtask

  initial begin
    logic [PTR_W-1:0] limit_plan [PHASES];
    int               idle_plan  [PHASES];
    in_word_t         w;

    limit_plan = '{13'd0, PTR_TOP, 13'd4096, 13'd48, 13'd0, 13'd9};
    limit_plan[4] = PTR_W'($urandom_range(4095, 1));
    idle_plan  = '{35, 35, 62, 62, 0, 0};

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Underflow from the base, byte and word round trips.
    send(mk(MODE_POP_BYTE, '0, '0));
    send(mk(MODE_POP_WORD, '0, '0));
    send(mk(MODE_PUSH_BYTE, '1, '0));
    send(mk(MODE_PUSH_BYTE, 64'hFFFF_FFFF_FFFF_FF00, '0));
    send(mk(MODE_POP_BYTE, '0, '0));
    send(mk(MODE_POP_BYTE, '0, '0));
    send(mk(MODE_PUSH_WORD, '1, '0));
    send(mk(MODE_PUSH_WORD, '0, '0));
    send(mk(MODE_PUSH_WORD, 64'h0123_4567_89AB_CDEF, '0));
    send(mk(MODE_POP_WORD, '0, '0));
    send(mk(MODE_POP_WORD, '0, '0));
    // Word pop across a byte push, unaligned.
    send(mk(MODE_PUSH_BYTE, 64'h5A, '0));
    send(mk(MODE_POP_WORD, '0, '0));
    send(mk(MODE_POP_BYTE, '0, '0));
    // Fill the top of memory, then overflow there.
    send(mk(MODE_SET_PTR, '0, 13'd4088));
    send(mk(MODE_PUSH_WORD, {$urandom, $urandom}, '0));
    send(mk(MODE_PUSH_BYTE, '1, '0));
    send(mk(MODE_PUSH_WORD, '1, '0));
    // Pointer load beyond memory clamps to the top.
    send(mk(MODE_SET_PTR, '0, PTR_TOP));
    send(mk(MODE_POP_BYTE, '0, '0));
    send(mk(MODE_SET_PTR, '0, 13'd4096));
    send(mk(MODE_POP_WORD, '0, '0));
    send(mk(MODE_SET_PTR, '0, '0));
    send(mk(MODE_SPARE_FIRST, {$urandom, $urandom}, PTR_W'($urandom_range(PTR_TOP, 0))));
    send(mk(MODE_SPARE_LAST, {$urandom, $urandom}, PTR_W'($urandom_range(PTR_TOP, 0))));

    for (int p = 0; p < PHASES; p++) begin
      set_limit(limit_plan[p]);
      idle_pct = idle_plan[p];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        random_item(w);
        send(w);
        if ($urandom_range(199) == 0) drain();
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
